// File: rtl/u8dec_pkg.sv
// u8dec_pkg: beat types and byte-class constants for the lenient UTF-8 decoder.
// No dependencies; used by utf8_lenient_stream_decoder.
package u8dec_pkg;

    // Input beat: one raw byte plus end-of-string mark
    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } t_in;

    // Output beat: one code point or one fallback byte
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  source_length;
        logic        last_of_run;
        logic        last_of_string;
    } t_out;

    // Byte class masks and patterns
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_PAT  = 8'h80;
    localparam logic [7:0] L2_MASK   = 8'hE0;
    localparam logic [7:0] L2_PAT    = 8'hC0;
    localparam logic [7:0] L3_MASK   = 8'hF0;
    localparam logic [7:0] L3_PAT    = 8'hE0;
    localparam logic [7:0] L4_MASK   = 8'hF8;
    localparam logic [7:0] L4_PAT    = 8'hF0;

    // Payload masks for lead and continuation bytes
    localparam logic [7:0] L2_DATA   = 8'h1F;
    localparam logic [7:0] L3_DATA   = 8'h0F;
    localparam logic [7:0] L4_DATA   = 8'h07;
    localparam logic [7:0] CONT_DATA = 8'h3F;

    // Sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

endpackage

// File: rtl/utf8_lenient_stream_decoder.sv
// utf8_lenient_stream_decoder: byte-in, code-point-out lenient UTF-8 decoder.
// Depends on u8dec_pkg (beat structs, byte-class constants).
//
//  channel | direction | valid        | stall        | payload
//  --------+-----------+--------------+--------------+----------------------
//  in      | to block  | i_in_valid   | o_in_stall   | i_in_data  (t_in)
//  out     | from block| o_out_valid  | i_out_stall  | o_out_data (t_out)
//
// One byte is decoded in the cycle it is accepted; its results (0 to 4) sit in
// a four-entry result register and leave one per cycle while output is not stalled.
// Sustained rate is one byte per cycle while each byte yields at most one result
// and the output is not stalled; a burst of fallback results holds the input back.
// Reset clears the pending-sequence state and empties the result register.
// Output stall holds the current result; input is taken again once the last
// queued result is leaving.
module utf8_lenient_stream_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  u8dec_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output u8dec_pkg::t_out   o_out_data
);
    import u8dec_pkg::*;

    // Pending sequence state
    logic [7:0] r_lead, n_lead;
    logic [7:0] r_tail [2];
    logic [7:0] n_tail [2];
    logic [2:0] r_exp, n_exp;
    logic [1:0] r_held, n_held;

    // Result register and drain pointer
    t_out       r_buf [4];
    t_out       n_res [4];
    logic [2:0] r_cnt, r_idx;
    logic [2:0] n_k;

    logic [2:0] rem;
    logic       in_fire, out_fire;

    // Decode scratch
    logic [7:0]  b;
    logic        e;
    logic        is_cont;
    logic [2:0]  cls;
    logic        consumed, complete, flush, push_b;
    logic [1:0]  flush_h;
    logic [20:0] cp;

    // Handshake
    assign rem         = r_cnt - r_idx;
    assign o_out_valid = (rem != 3'd0);
    assign o_out_data  = r_buf[r_idx[1:0]];
    assign out_fire    = o_out_valid && !i_out_stall;
    assign o_in_stall  = !((rem == 3'd0) || ((rem == 3'd1) && !i_out_stall));
    assign in_fire     = i_in_valid && !o_in_stall;

    // Lead-byte class
    always_comb begin
        if (!b[7])                          cls = LEN_1;
        else if ((b & L2_MASK) == L2_PAT)   cls = LEN_2;
        else if ((b & L3_MASK) == L3_PAT)   cls = LEN_3;
        else if ((b & L4_MASK) == L4_PAT)   cls = LEN_4;
        else                                cls = LEN_1;
    end

    // Code point assembly for a completing sequence
    always_comb begin
        case (r_exp)
            LEN_2:   cp = {10'd0, r_lead[4:0] & L2_DATA[4:0], b[5:0] & CONT_DATA[5:0]};
            LEN_3:   cp = {5'd0, r_lead[3:0] & L3_DATA[3:0],
                           r_tail[0][5:0] & CONT_DATA[5:0], b[5:0] & CONT_DATA[5:0]};
            LEN_4:   cp = {r_lead[2:0] & L4_DATA[2:0], r_tail[0][5:0] & CONT_DATA[5:0],
                           r_tail[1][5:0] & CONT_DATA[5:0], b[5:0] & CONT_DATA[5:0]};
            default: cp = '0;
        endcase
    end

    // Next state and result list for the incoming byte
    always_comb begin
        b        = i_in_data.in_byte;
        e        = i_in_data.string_end;
        is_cont  = ((b & CONT_MASK) == CONT_PAT);
        n_lead   = r_lead;
        n_tail   = r_tail;
        n_exp    = r_exp;
        n_held   = r_held;
        consumed = 1'b0;
        complete = 1'b0;
        flush    = 1'b0;
        flush_h  = r_held;
        push_b   = 1'b0;
        for (int i = 0; i < 4; i++) begin
            n_res[i] = '0;
        end
        n_k = 3'd0;

        // Pending sequence handling
        if (r_exp != LEN_NONE) begin
            if (is_cont) begin
                consumed = 1'b1;
                if ({1'b0, r_held} + 3'd2 == r_exp) begin
                    complete = 1'b1;
                    n_exp    = LEN_NONE;
                    n_held   = 2'd0;
                end else if (r_held < 2'd2) begin
                    n_tail[r_held[0]] = b;
                    n_held = r_held + 2'd1;
                    if (e) begin
                        flush   = 1'b1;
                        flush_h = r_held + 2'd1;
                        n_exp   = LEN_NONE;
                        n_held  = 2'd0;
                    end
                end else begin
                    // held count out of range: break the sequence
                    flush  = 1'b1;
                    push_b = 1'b1;
                    n_exp  = LEN_NONE;
                    n_held = 2'd0;
                end
            end else begin
                flush  = 1'b1;
                n_exp  = LEN_NONE;
                n_held = 2'd0;
            end
        end

        // Fresh byte
        if (!consumed) begin
            if (cls == LEN_1 || e) begin
                push_b = 1'b1;
            end else begin
                n_lead = b;
                n_exp  = cls;
                n_held = 2'd0;
            end
        end

        // Fill result slots in order
        if (complete) begin
            n_res[0].code_point    = cp;
            n_res[0].source_length = r_exp;
            n_k = 3'd1;
        end
        if (flush) begin
            n_res[0].code_point    = {13'd0, r_lead};
            n_res[0].source_length = LEN_1;
            n_res[1].code_point    = {13'd0, n_tail[0]};
            n_res[1].source_length = LEN_1;
            n_res[2].code_point    = {13'd0, n_tail[1]};
            n_res[2].source_length = LEN_1;
            n_k = 3'd1 + {1'b0, flush_h};
        end
        if (push_b) begin
            n_res[n_k[1:0]].code_point    = {13'd0, b};
            n_res[n_k[1:0]].source_length = LEN_1;
            n_k = n_k + 3'd1;
        end

        // Mark the final result of this byte
        if (n_k != 3'd0) begin
            n_res[n_k[1:0] - 2'd1].last_of_run    = 1'b1;
            n_res[n_k[1:0] - 2'd1].last_of_string = e;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_exp  <= LEN_NONE;
            r_held <= '0;
            r_cnt  <= '0;
            r_idx  <= '0;
        end else begin
            if (in_fire) begin
                r_lead <= n_lead;
                r_exp  <= n_exp;
                r_held <= n_held;
            end
            if (out_fire) begin
                r_idx <= r_idx + 3'd1;
            end
            if (in_fire && n_k != 3'd0) begin
                r_cnt <= n_k;
                r_idx <= 3'd0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tail <= n_tail;
            if (n_k != 3'd0) begin
                r_buf <= n_res;
            end
        end
    end

endmodule
